// File: hdl/swpc_pkg.sv
// Shared types, constants and helper functions of the scaled window pixel compositor.
`timescale 1ns / 1ps
`default_nettype none

package swpc_pkg;

  localparam int TEXEL_DEPTH_DEF = 65536;
  localparam int MAX_WIN_DIM_DEF = 256;
  localparam int COORD_BITS_DEF  = 11;

  // Signed width of screen-space arithmetic, enough for every position and size in range.
  localparam int SCW = 15;

  localparam int TITLE_H  = 30;
  localparam int CORNER_R = 10;
  localparam int CORNER_R2 = CORNER_R * CORNER_R;

  // Title bar buttons: centers, vertical band and squared radius.
  localparam int BTN_X0  = 16;
  localparam int BTN_X1  = 36;
  localparam int BTN_X2  = 56;
  localparam int BTN_YC  = 14;
  localparam int BTN_Y_LO = 8;
  localparam int BTN_Y_HI = 20;
  localparam int BTN_R   = 6;
  localparam int BTN_R2  = BTN_R * BTN_R;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [31:0] COLOR_RED    = 32'hFFFF_5F57;
  localparam logic [31:0] COLOR_YELLOW = 32'hFFFE_BC2E;
  localparam logic [31:0] COLOR_GREEN  = 32'hFF28_C840;

  localparam logic [15:0] TITLE_BG_W   = 16'd40;
  localparam logic [15:0] TITLE_TINT_W = 16'd60;
  localparam logic [7:0]  FADE_OPAQUE  = 8'd255;

  // Exact division by 100 and by 255 over the operand ranges used here.
  localparam logic [17:0] RECIP100 = 18'd167773;
  localparam logic [16:0] RECIP255 = 17'd65794;
  localparam int RECIP_SH = 24;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    REG_WIN_LEFT    = 3'd0,
    REG_WIN_TOP     = 3'd1,
    REG_WIN_COLS    = 3'd2,
    REG_WIN_ROWS    = 3'd3,
    REG_SCALE       = 3'd4,
    REG_FADE        = 3'd5,
    REG_TITLE_COLOR = 3'd6
  } reg_e;

  typedef enum logic [1:0] {
    BTN_NONE,
    BTN_RED,
    BTN_YELLOW,
    BTN_GREEN
  } btn_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] taddr;
    logic [31:0] tval;
    logic [10:0] px;
    logic [10:0] py;
    logic [31:0] bg;
  } item_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] taddr;
    logic [31:0] tval;
    logic [31:0] bg;
    logic        write;
    logic        title;
    logic [31:0] tcol;
  } div_tag_t;

  function automatic logic [7:0] div100(input logic [15:0] n);
    logic [33:0] p;
    p = 34'(n) * 34'(RECIP100);
    return p[RECIP_SH +: 8];
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [32:0] p;
    p = 33'(n) * 33'(RECIP255);
    return p[RECIP_SH +: 8];
  endfunction

endpackage

`default_nettype wire

// File: hdl/scaled_window_pixel_compositor_top.sv
// Top level of the scaled window pixel compositor: registers, pixel pipeline and texel memory.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one word per clock on its input channel, whether it is a texel load or a
// pixel to composite, as long as the output side keeps claiming results. Every word runs
// through one fixed pipeline of thirteen stages plus one stage per quotient bit of the
// texture coordinate division, clog2(MAX_WIN_DIM + 1) of them. At the defaults that is
// twenty-two register stages. Loads and texel reads share the single port of the texel
// memory at one pipeline stage, so a pixel always sees exactly the loads that came before
// it on the channel. Load words give no result, pixel words give exactly one. The whole
// pipeline, input included, halts only while a result sits unclaimed at the output. The
// user must write configuration registers through the APB port only while no word is in
// flight; the block itself does not enforce it. The geometry derived from them is
// registered, and the entry delay line holds each word back until it has settled. The texel
// memory is not cleared at reset: a pixel that samples a texel never loaded returns
// undefined content.
module scaled_window_pixel_compositor_top import swpc_pkg::*; #(
  parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF,
  parameter int MAX_WIN_DIM = MAX_WIN_DIM_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] texel_addr_i,
  input  logic [31:0] texel_value_i,
  input  logic [10:0] screen_x_i,
  input  logic [10:0] screen_y_i,
  input  logic [31:0] bg_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_color_o,
  output logic        write_pixel_o
);

  localparam int DW  = $clog2(MAX_WIN_DIM + 1);
  localparam int SWW = DW + 1;
  localparam int SHW = DW + 2;
  localparam int QW  = DW;
  localparam int RW  = SHW + QW;
  localparam int AW  = $clog2(TEXEL_DEPTH);
  localparam int TAW = 2 * DW + 1;
  localparam int PWW = DW + 7;
  localparam int PHW = DW + 8;
  localparam int DLY = 5;
  localparam logic [10:0] CMASK = (COORD_BITS >= 11) ? 11'h7FF : 11'((1 << COORD_BITS) - 1);

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic signed [11:0] win_left_q, win_top_q;
  logic [8:0]         win_cols_q, win_rows_q;
  logic [6:0]         scale_q;
  logic [7:0]         fade_q;
  logic [23:0]        title_color_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q    <= '0;
      win_top_q     <= '0;
      win_cols_q    <= 9'd64;
      win_rows_q    <= 9'd64;
      scale_q       <= 7'd100;
      fade_q        <= 8'd255;
      title_color_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_WIN_LEFT:    win_left_q    <= pwdata[11:0];
        REG_WIN_TOP:     win_top_q     <= pwdata[11:0];
        REG_WIN_COLS:    win_cols_q    <= pwdata[8:0];
        REG_WIN_ROWS:    win_rows_q    <= pwdata[8:0];
        REG_SCALE:       scale_q       <= pwdata[6:0];
        REG_FADE:        fade_q        <= pwdata[7:0];
        REG_TITLE_COLOR: title_color_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WIN_LEFT:    prdata = {20'b0, win_left_q};
      REG_WIN_TOP:     prdata = {20'b0, win_top_q};
      REG_WIN_COLS:    prdata = {23'b0, win_cols_q};
      REG_WIN_ROWS:    prdata = {23'b0, win_rows_q};
      REG_SCALE:       prdata = {25'b0, scale_q};
      REG_FADE:        prdata = {24'b0, fade_q};
      REG_TITLE_COLOR: prdata = {8'b0, title_color_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Window geometry, recomputed every cycle from the registers in four levels.
  // ---------------------------------------------------------------------------------------
  function automatic logic [DW-1:0] sat_dim(input logic [8:0] v);
    if (v == '0) return DW'(1);
    if (int'(v) > MAX_WIN_DIM) return DW'(MAX_WIN_DIM);
    return DW'(v);
  endfunction

  logic [DW-1:0]        cols_q, rows_q;
  logic [PWW-1:0]       prod_w_q;
  logic [PHW-1:0]       prod_h_q;
  logic [PWW+17:0]      sw_full;
  logic [PHW+17:0]      sh_full;
  logic [SWW-1:0]       sw_q;
  logic [SHW-1:0]       sh_q, shm30_q;
  logic                 tiny_q;
  logic signed [SCW-1:0] hw_x, hw_y, hr_x, hr_y, half_x, half_y;
  logic signed [SCW-1:0] ax_q, ay_q, axe_q, aye_q;

  assign sw_full = (PWW+18)'(prod_w_q) * (PWW+18)'(RECIP100);
  assign sh_full = (PHW+18)'(prod_h_q) * (PHW+18)'(RECIP100);

  // Halving toward zero: bias negative offsets by one before the arithmetic shift.
  assign hw_x   = SCW'(cols_q) - SCW'(sw_q);
  assign hw_y   = SCW'(rows_q) + SCW'(TITLE_H) - SCW'(sh_q);
  assign hr_x   = hw_x + $signed(SCW'(hw_x[SCW-1]));
  assign hr_y   = hw_y + $signed(SCW'(hw_y[SCW-1]));
  assign half_x = hr_x >>> 1;
  assign half_y = hr_y >>> 1;

  always_ff @(posedge clk_i) begin
    cols_q   <= sat_dim(win_cols_q);
    rows_q   <= sat_dim(win_rows_q);
    prod_w_q <= PWW'(sat_dim(win_cols_q)) * PWW'(scale_q);
    prod_h_q <= (PHW'(sat_dim(win_rows_q)) + PHW'(TITLE_H)) * PHW'(scale_q);
    sw_q     <= SWW'(sw_full >> RECIP_SH);
    sh_q     <= SHW'(sh_full >> RECIP_SH);
    tiny_q   <= (sw_q == '0) || (sh_q < SHW'(TITLE_H));
    shm30_q  <= sh_q - SHW'(TITLE_H);
    ax_q     <= SCW'(win_left_q) + half_x;
    ay_q     <= SCW'(win_top_q) + half_y;
    axe_q    <= ax_q + $signed(SCW'(sw_q));
    aye_q    <= ay_q + $signed(SCW'(sh_q));
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control: every stage moves together unless a result waits unclaimed.
  // ---------------------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Entry delay line; it lets the geometry settle before any word needs it.
  logic  dv_q [DLY];
  item_t dl_q [DLY];
  item_t in_item;

  assign in_item = '{cmd: cmd_e'(cmd_i), taddr: texel_addr_i, tval: texel_value_i,
                     px: screen_x_i & CMASK, py: screen_y_i & CMASK, bg: bg_pixel_i};

  for (genvar i = 0; i < DLY; i++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i] <= 1'b0;
      end else if (adv) begin
        dv_q[i] <= (i == 0) ? in_valid_i : dv_q[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dl_q[i] <= (i == 0) ? in_item : dl_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Box test and window-relative coordinates.
  logic signed [SCW-1:0] pxs, pys;
  logic                  inbox_d;
  item_t                 it6_q;
  logic                  v6_q, inbox6_q;
  logic [SWW-1:0]        sx6_q;
  logic [SHW-1:0]        sy6_q;

  assign pxs = SCW'(dl_q[DLY-1].px);
  assign pys = SCW'(dl_q[DLY-1].py);
  assign inbox_d = !tiny_q && (pxs >= ax_q) && (pys >= ay_q) && (pxs < axe_q) && (pys < aye_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it6_q    <= dl_q[DLY-1];
      inbox6_q <= inbox_d;
      sx6_q    <= SWW'(pxs - ax_q);
      sy6_q    <= SHW'(pys - ay_q);
    end
  end

  // Rounded corners, title buttons and the content sampling products.
  function automatic logic btn_hit(input logic [SWW-1:0] sx, input int c, input logic [3:0] ady);
    int d;
    if (int'(sx) < c - BTN_R || int'(sx) > c + BTN_R) return 1'b0;
    d = (int'(sx) >= c) ? int'(sx) - c : c - int'(sx);
    return (d * d + int'(ady) * int'(ady)) <= BTN_R2;
  endfunction

  logic       c_top, c_left, c_right, c_bot, corner;
  logic [3:0] cdx, cdy, ady;
  logic [7:0] dsq;
  logic       band, mask_d;
  btn_e       btn_d;

  assign c_top   = sy6_q < SHW'(CORNER_R);
  assign c_left  = sx6_q < SWW'(CORNER_R);
  assign c_right = (sw_q >= SWW'(CORNER_R)) && (sx6_q >= sw_q - SWW'(CORNER_R));
  assign c_bot   = sy6_q >= sh_q - SHW'(CORNER_R);

  // Left corners win where a narrow window has both corners on the same pixel.
  always_comb begin
    corner = 1'b0;
    cdx    = '0;
    cdy    = '0;
    priority if (c_top && c_left) begin
      corner = 1'b1;
      cdx    = 4'(SWW'(CORNER_R) - sx6_q);
      cdy    = 4'(SHW'(CORNER_R) - sy6_q);
    end else if (c_top && c_right) begin
      corner = 1'b1;
      cdx    = 4'(sx6_q - (sw_q - SWW'(CORNER_R)));
      cdy    = 4'(SHW'(CORNER_R) - sy6_q);
    end else if (c_bot && c_left) begin
      corner = 1'b1;
      cdx    = 4'(SWW'(CORNER_R) - sx6_q);
      cdy    = 4'(sy6_q - (sh_q - SHW'(CORNER_R)));
    end else if (c_bot && c_right) begin
      corner = 1'b1;
      cdx    = 4'(sx6_q - (sw_q - SWW'(CORNER_R)));
      cdy    = 4'(sy6_q - (sh_q - SHW'(CORNER_R)));
    end else begin
      corner = 1'b0;
    end
  end

  assign dsq    = 8'(cdx) * 8'(cdx) + 8'(cdy) * 8'(cdy);
  assign mask_d = corner && (dsq > 8'(CORNER_R2));
  assign band   = (sy6_q >= SHW'(BTN_Y_LO)) && (sy6_q <= SHW'(BTN_Y_HI));
  assign ady    = (sy6_q >= SHW'(BTN_YC)) ? 4'(sy6_q - SHW'(BTN_YC)) : 4'(SHW'(BTN_YC) - sy6_q);

  always_comb begin
    btn_d = BTN_NONE;
    priority if (band && btn_hit(sx6_q, BTN_X0, ady)) btn_d = BTN_RED;
    else if (band && btn_hit(sx6_q, BTN_X1, ady))     btn_d = BTN_YELLOW;
    else if (band && btn_hit(sx6_q, BTN_X2, ady))     btn_d = BTN_GREEN;
    else                                              btn_d = BTN_NONE;
  end

  item_t         it7_q;
  logic          v7_q, wr7_q, title7_q;
  btn_e          btn7_q;
  logic [RW-1:0] numx7_q, numy7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it7_q    <= it6_q;
      wr7_q    <= inbox6_q && !mask_d;
      title7_q <= sy6_q < SHW'(TITLE_H);
      btn7_q   <= btn_d;
      numx7_q  <= RW'(sx6_q) * RW'(cols_q);
      numy7_q  <= RW'(SHW'(sy6_q - SHW'(TITLE_H))) * RW'(rows_q);
    end
  end

  // Title bar tint: 40 percent background, 60 percent tint, per channel.
  logic [15:0]   tn_d [3];
  item_t         it8_q;
  logic          v8_q, wr8_q, title8_q;
  btn_e          btn8_q;
  logic [RW-1:0] numx8_q, numy8_q;
  logic [15:0]   tn8_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tn_d[c] = 16'(it7_q.bg[8*c +: 8]) * TITLE_BG_W + 16'(title_color_q[8*c +: 8]) * TITLE_TINT_W;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it8_q    <= it7_q;
      wr8_q    <= wr7_q;
      title8_q <= title7_q;
      btn8_q   <= btn7_q;
      numx8_q  <= numx7_q;
      numy8_q  <= numy7_q;
      tn8_q    <= tn_d;
    end
  end

  logic [31:0]   tcol_d;
  div_tag_t      tag9_q;
  logic          v9_q;
  logic [RW-1:0] numx9_q, numy9_q;

  always_comb begin
    unique case (btn8_q)
      BTN_RED:    tcol_d = COLOR_RED;
      BTN_YELLOW: tcol_d = COLOR_YELLOW;
      BTN_GREEN:  tcol_d = COLOR_GREEN;
      BTN_NONE:   tcol_d = ALPHA_OPAQUE | {8'b0, div100(tn8_q[2]), div100(tn8_q[1]),
                                           div100(tn8_q[0])};
      default:    tcol_d = ALPHA_OPAQUE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag9_q  <= '{cmd: it8_q.cmd, taddr: it8_q.taddr, tval: it8_q.tval, bg: it8_q.bg,
                   write: wr8_q, title: title8_q, tcol: tcol_d};
      numx9_q <= numx8_q;
      numy9_q <= numy8_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (adv) begin
      v6_q <= dv_q[DLY-1];
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // Nearest-neighbor source coordinates: sx * cols / sw and (sy - 30) * rows / (sh - 30).
  logic          dv;
  div_tag_t      dtag;
  logic [QW-1:0] qx, qy;

  swpc_div #(
    .DEN_W (SHW),
    .QW    (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v9_q),
    .tag_i   (tag9_q),
    .num_x_i (numx9_q),
    .num_y_i (numy9_q),
    .den_x_i (SHW'(sw_q)),
    .den_y_i (shm30_q),
    .valid_o (dv),
    .tag_o   (dtag),
    .quo_x_o (qx),
    .quo_y_o (qy)
  );

  // Texel address, with clamping to the image and a range check against the memory.
  logic [QW-1:0]  qxc, qyc;
  logic [TAW-1:0] taddr_pix;
  logic           ok_d;
  logic [AW-1:0]  maddr_d;
  div_tag_t       tag11_q, tag12_q;
  logic           v11_q, v12_q, ok11_q, ok12_q;
  logic [AW-1:0]  maddr11_q;

  assign qxc       = (qx >= cols_q) ? cols_q - DW'(1) : qx;
  assign qyc       = (qy >= rows_q) ? rows_q - DW'(1) : qy;
  assign taddr_pix = TAW'(qyc) * TAW'(cols_q) + TAW'(qxc);
  assign ok_d      = (dtag.cmd == CMD_LOAD) ? (int'(dtag.taddr) < TEXEL_DEPTH)
                                            : (int'(taddr_pix) < TEXEL_DEPTH);
  assign maddr_d   = (dtag.cmd == CMD_LOAD) ? AW'(dtag.taddr) : AW'(taddr_pix);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag11_q   <= dtag;
      ok11_q    <= ok_d;
      maddr11_q <= maddr_d;
      tag12_q   <= tag11_q;
      ok12_q    <= ok11_q;
    end
  end

  // Texel memory: one port, a load writes and every other word reads at the same stage.
  logic [31:0] texel_mem [TEXEL_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (v11_q && tag11_q.cmd == CMD_LOAD && ok11_q) begin
        texel_mem[maddr11_q] <= tag11_q.tval;
      end
      rdata_q <= texel_mem[maddr11_q];
    end
  end

  // Color selection and the fade blend against the background.
  logic [31:0] col_d;
  logic [15:0] fn_d [3];
  logic [7:0]  fade_inv;
  logic        v13_q, wr13_q;
  cmd_e        cmd13_q;
  logic [31:0] col13_q;
  logic [15:0] fn13_q [3];
  logic [31:0] final_d;

  assign fade_inv = FADE_OPAQUE - fade_q;
  assign col_d    = tag12_q.title ? tag12_q.tcol : (ok12_q ? rdata_q : 32'b0);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fn_d[c] = 16'(col_d[8*c +: 8]) * 16'(fade_q) + 16'(tag12_q.bg[8*c +: 8]) * 16'(fade_inv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr13_q  <= tag12_q.write;
      cmd13_q <= tag12_q.cmd;
      col13_q <= col_d;
      fn13_q  <= fn_d;
    end
  end

  always_comb begin
    if (!wr13_q) begin
      final_d = '0;
    end else if (fade_q != FADE_OPAQUE) begin
      final_d = ALPHA_OPAQUE | {8'b0, div255(fn13_q[2]), div255(fn13_q[1]), div255(fn13_q[0])};
    end else begin
      final_d = col13_q;
    end
  end

  // Output register; only pixel words leave a result.
  logic [31:0] color_q;
  logic        write_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q       <= 1'b0;
      v12_q       <= 1'b0;
      v13_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v11_q       <= dv;
      v12_q       <= v11_q;
      v13_q       <= v12_q;
      out_valid_q <= v13_q && (cmd13_q == CMD_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      color_q <= final_d;
      write_q <= wr13_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = color_q;
  assign write_pixel_o = write_q;

endmodule

`default_nettype wire

// File: hdl/swpc_div.sv
// Pipelined restoring divider for the two texture coordinates, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module swpc_div import swpc_pkg::*; #(
  parameter int DEN_W = 10,
  parameter int QW    = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  div_tag_t              tag_i,
  input  logic [DEN_W+QW-1:0]   num_x_i,
  input  logic [DEN_W+QW-1:0]   num_y_i,
  input  logic [DEN_W-1:0]      den_x_i,
  input  logic [DEN_W-1:0]      den_y_i,
  output logic                  valid_o,
  output div_tag_t              tag_o,
  output logic [QW-1:0]         quo_x_o,
  output logic [QW-1:0]         quo_y_o
);

  localparam int RW = DEN_W + QW;

  logic            v_q   [QW];
  div_tag_t        tag_q [QW];
  logic [RW-1:0]   rx_q  [QW];
  logic [RW-1:0]   ry_q  [QW];
  logic [QW-1:0]   qx_q  [QW];
  logic [QW-1:0]   qy_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic          v_in;
    div_tag_t      t_in;
    logic [RW-1:0] rx_in, ry_in, dx_s, dy_s, rx_d, ry_d;
    logic [QW-1:0] qx_in, qy_in, qx_d, qy_d;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign t_in  = tag_i;
      assign rx_in = num_x_i;
      assign ry_in = num_y_i;
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign t_in  = tag_q[k-1];
      assign rx_in = rx_q[k-1];
      assign ry_in = ry_q[k-1];
      assign qx_in = qx_q[k-1];
      assign qy_in = qy_q[k-1];
    end

    assign dx_s = RW'(den_x_i) << B;
    assign dy_s = RW'(den_y_i) << B;

    always_comb begin
      rx_d = rx_in;
      qx_d = qx_in;
      ry_d = ry_in;
      qy_d = qy_in;
      if (rx_in >= dx_s) begin
        rx_d = rx_in - dx_s;
        qx_d = qx_in | (QW'(1) << B);
      end
      if (ry_in >= dy_s) begin
        ry_d = ry_in - dy_s;
        qy_d = qy_in | (QW'(1) << B);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[k] <= t_in;
        rx_q[k]  <= rx_d;
        ry_q[k]  <= ry_d;
        qx_q[k]  <= qx_d;
        qy_q[k]  <= qy_d;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign tag_o   = tag_q[QW-1];
  assign quo_x_o = qx_q[QW-1];
  assign quo_y_o = qy_q[QW-1];

endmodule

`default_nettype wire

// File: test/scaled_window_pixel_compositor_top_tb.sv
// Self-checking testbench of the scaled window pixel compositor top level.
`timescale 1ns / 1ps

// The bench drives texel-load and pixel words into the compositor and writes every
// configuration register over the APB port between phases. A behavioral predictor
// computes the color and write flag of each accepted pixel word. A separate process
// compares each result word with the oldest prediction. Before any pixel word that
// would sample a texel never loaded, the bench sends a load for that texel first.
// The texel memory is not cleared at reset, so this keeps every sample defined.
module scaled_window_pixel_compositor_top_tb;
  import swpc_pkg::*;

  localparam int  HALF_PERIOD = 4;
  localparam int  DRAIN_CYCLES = 48;        // comfortably beyond the pipeline depth
  localparam int  CYCLE_LIMIT = 1_000_000;

  typedef struct {
    logic [31:0] color;
    logic        write;
  } pixel_result_t;

  typedef struct {
    pixel_result_t res;
    bit            samples;                 // the pixel reads a content texel
    int            taddr;
  } pixel_forecast_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = CMD_LOAD;
  logic [15:0] texel_addr_i = '0;
  logic [31:0] texel_value_i = '0;
  logic [10:0] screen_x_i = '0;
  logic [10:0] screen_y_i = '0;
  logic [31:0] bg_pixel_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] pixel_color_o;
  logic        write_pixel_o;

  scaled_window_pixel_compositor_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .texel_addr_i, .texel_value_i, .screen_x_i,
    .screen_y_i, .bg_pixel_i, .out_valid_o, .out_ready_i, .pixel_color_o, .write_pixel_o
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // The bench's own copy of the configuration and of the texel memory.
  logic signed [11:0] left_q = '0;
  logic signed [11:0] top_q = '0;
  logic [8:0]  cols_q = 9'd64;
  logic [8:0]  rows_q = 9'd64;
  logic [6:0]  scale_q = 7'd100;
  logic [7:0]  fade_q = 8'd255;
  logic [23:0] tint_q = '0;
  logic [31:0] texels [TEXEL_DEPTH_DEF];
  bit          loaded [TEXEL_DEPTH_DEF];

  pixel_result_t pending_pixels [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int cycle_count = 0;

  function automatic logic [7:0] chan_mix(logic [31:0] a, logic [31:0] b, int wa, int wb,
                                          int dv, int sh);
    int ca;
    int cb;
    ca = (a >> sh) & 8'hFF;
    cb = (b >> sh) & 8'hFF;
    return 8'((ca * wa + cb * wb) / dv);
  endfunction

  function automatic logic [31:0] rgb_mix(logic [31:0] a, logic [31:0] b, int wa, int wb,
                                          int dv);
    return {8'hFF, chan_mix(a, b, wa, wb, dv, 16), chan_mix(a, b, wa, wb, dv, 8),
            chan_mix(a, b, wa, wb, dv, 0)};
  endfunction

  function automatic int sat_dim(logic [8:0] v);
    if (v < 1) return 1;
    if (v > MAX_WIN_DIM_DEF) return MAX_WIN_DIM_DEF;
    return int'(v);
  endfunction

  function automatic bit outside_arc(int dx, int dy);
    return dx * dx + dy * dy > CORNER_R2;
  endfunction

  // Computes what the compositor answers for one pixel under the current settings.
  function automatic pixel_forecast_t forecast_pixel(logic [10:0] sx_in, logic [10:0] sy_in,
                                                     logic [31:0] bg);
    pixel_forecast_t f;
    int cols, rows, sw, sh, ax, ay, px, py, sx, sy, ox, oy, dy, d0, d1, d2;
    bit masked;
    logic [31:0] color;
    f.res.color = '0;
    f.res.write = 1'b0;
    f.samples = 1'b0;
    f.taddr = 0;
    masked = 1'b0;
    px = int'(sx_in);
    py = int'(sy_in);
    cols = sat_dim(cols_q);
    rows = sat_dim(rows_q);
    sw = cols * int'(scale_q) / 100;
    sh = (rows + TITLE_H) * int'(scale_q) / 100;
    if (sw < 1 || sh < TITLE_H) return f;
    ax = int'(left_q) + (cols - sw) / 2;
    ay = int'(top_q) + (rows + TITLE_H - sh) / 2;
    if (px < ax || py < ay || px >= ax + sw || py >= ay + sh) return f;
    sx = px - ax;
    sy = py - ay;
    // Rounded corners; the right ones only exist once the window is a corner wide.
    if (sy < CORNER_R && sx < CORNER_R) begin
      masked = outside_arc(CORNER_R - sx, CORNER_R - sy);
    end else if (sy < CORNER_R && sw >= CORNER_R && sx >= sw - CORNER_R) begin
      masked = outside_arc(sx - (sw - CORNER_R), CORNER_R - sy);
    end else if (sy >= sh - CORNER_R && sx < CORNER_R) begin
      masked = outside_arc(CORNER_R - sx, sy - (sh - CORNER_R));
    end else if (sy >= sh - CORNER_R && sw >= CORNER_R && sx >= sw - CORNER_R) begin
      masked = outside_arc(sx - (sw - CORNER_R), sy - (sh - CORNER_R));
    end
    if (masked) return f;
    if (sy < TITLE_H) begin
      color = rgb_mix(bg, {8'h00, tint_q}, 40, 60, 100);
      if (sy >= BTN_Y_LO && sy <= BTN_Y_HI) begin
        dy = sy - BTN_YC;
        d0 = sx - BTN_X0;
        d1 = sx - BTN_X1;
        d2 = sx - BTN_X2;
        if (d0 * d0 + dy * dy <= BTN_R2) color = COLOR_RED;
        else if (d1 * d1 + dy * dy <= BTN_R2) color = COLOR_YELLOW;
        else if (d2 * d2 + dy * dy <= BTN_R2) color = COLOR_GREEN;
      end
    end else begin
      ox = sx * cols / sw;
      oy = (sy - TITLE_H) * rows / (sh - TITLE_H);
      if (ox >= cols) ox = cols - 1;
      if (oy >= rows) oy = rows - 1;
      f.samples = 1'b1;
      f.taddr = oy * cols + ox;
      color = (f.taddr < TEXEL_DEPTH_DEF) ? texels[f.taddr] : '0;
    end
    if (fade_q < FADE_OPAQUE) color = rgb_mix(color, bg, int'(fade_q), 255 - int'(fade_q), 255);
    f.res.color = color;
    f.res.write = 1'b1;
    return f;
  endfunction

  // Sends one word. Entered and left just after a rising edge; valid stays high afterwards.
  task automatic send_word(cmd_e cmd, logic [15:0] taddr, logic [31:0] tval,
                           logic [10:0] px, logic [10:0] py, logic [31:0] bg);
    pixel_forecast_t f;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    texel_addr_i <= taddr;
    texel_value_i <= tval;
    screen_x_i <= px;
    screen_y_i <= py;
    bg_pixel_i <= bg;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CMD_LOAD) begin
      texels[taddr] = tval;
      loaded[taddr] = 1'b1;
    end else begin
      f = forecast_pixel(px, py, bg);
      pending_pixels.push_back(f.res);
    end
  endtask

  task automatic send_load(logic [15:0] taddr, logic [31:0] tval);
    send_word(CMD_LOAD, taddr, tval, 11'($urandom), 11'($urandom), $urandom);
  endtask

  // Loads the sampled texel first if it was never written.
  task automatic send_pixel(logic [10:0] px, logic [10:0] py, logic [31:0] bg);
    pixel_forecast_t f;
    f = forecast_pixel(px, py, bg);
    if (f.samples && !loaded[f.taddr]) send_load(16'(f.taddr), $urandom);
    send_word(CMD_PIXEL, 16'($urandom), $urandom, px, py, bg);
  endtask

  // Waits until every result is in, then lets trailing loads leave the pipeline.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(r) << 2;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_WIN_LEFT:    left_q = v[11:0];
      REG_WIN_TOP:     top_q = v[11:0];
      REG_WIN_COLS:    cols_q = v[8:0];
      REG_WIN_ROWS:    rows_q = v[8:0];
      REG_SCALE:       scale_q = v[6:0];
      REG_FADE:        fade_q = v[7:0];
      REG_TITLE_COLOR: tint_q = v[23:0];
      default: ;
    endcase
  endtask

  // Writes the whole register set; the caller makes sure the block is idle.
  task automatic set_window(int left, int top, int cols, int rows, int scale, int fade,
                            logic [23:0] tint);
    reg_write(REG_WIN_LEFT, 32'(left));
    reg_write(REG_WIN_TOP, 32'(top));
    reg_write(REG_WIN_COLS, 32'(cols));
    reg_write(REG_WIN_ROWS, 32'(rows));
    reg_write(REG_SCALE, 32'(scale));
    reg_write(REG_FADE, 32'(fade));
    reg_write(REG_TITLE_COLOR, {8'h00, tint});
  endtask

  // Random words: mostly pixels near the window box, some loads, some stray pixels.
  task automatic run_random(int n);
    int w;
    int h;
    int pick;
    w = sat_dim(cols_q);
    h = sat_dim(rows_q) + TITLE_H;
    w = (w * int'(scale_q) / 100 > w) ? w * int'(scale_q) / 100 : w;
    h = (h * int'(scale_q) / 100 > h) ? h * int'(scale_q) / 100 : h;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_load(16'($urandom), $urandom);
      end else if (pick < 32) begin
        send_pixel(11'($urandom), 11'($urandom), $urandom);
      end else begin
        send_pixel(11'(int'(left_q) - 4 + $urandom_range(0, w + 8)),
                   11'(int'(top_q) - 4 + $urandom_range(0, h + 8)), $urandom);
      end
    end
  endtask

  // Picks a random but mostly well-formed window and exercises it.
  task automatic run_random_window(int n);
    drain();
    set_window($urandom_range(0, 1900) - 40, $urandom_range(0, 1900) - 40,
               $urandom_range(1, 40), $urandom_range(1, 40),
               ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(60, 100),
               ($urandom_range(1) == 0) ? 255 : $urandom_range(0, 255), 24'($urandom));
    run_random(n);
  endtask

  // Directed words at the reset settings: corners, buttons, content and field extremes.
  task automatic test_directed();
    send_load(16'hFFFF, 32'hFFFF_FFFF);
    send_load(16'h0000, 32'h0000_0000);
    send_pixel(11'd0, 11'd0, 32'hFFFF_FFFF);       // masked top-left corner
    send_pixel(11'd63, 11'd0, 32'h0000_0000);      // masked top-right corner
    send_pixel(11'd0, 11'd93, 32'h1234_5678);      // masked bottom-left corner
    send_pixel(11'd63, 11'd93, 32'h8765_4321);     // masked bottom-right corner
    send_pixel(11'd16, 11'd14, $urandom);          // red button
    send_pixel(11'd36, 11'd14, $urandom);          // yellow button
    send_pixel(11'd56, 11'd14, $urandom);          // green button
    send_pixel(11'd30, 11'd5, 32'hFFFF_FFFF);      // plain title bar
    send_pixel(11'd0, 11'd30, $urandom);           // first content row
    send_pixel(11'd63, 11'd93, $urandom);
    send_pixel(11'd32, 11'd60, $urandom);
    send_pixel(11'd2047, 11'd2047, $urandom);      // far outside
    send_pixel(11'd64, 11'd40, $urandom);          // just right of the box
    send_pixel(11'd10, 11'd94, $urandom);          // just below the box
    drain();
  endtask

  // Extreme and special settings, each with a short random burst.
  task automatic test_extremes();
    set_window(-2048, -2048, 256, 1, 100, 255, 24'hFFFFFF);
    run_random(12);
    drain();
    set_window(2047, 2047, 1, 256, 100, 0, 24'h000000);   // fully faded, far corner
    run_random(12);
    drain();
    set_window(0, 0, 0, 511, 100, 128, 24'h00FF00);       // sizes saturate
    run_random(12);
    drain();
    set_window(20, 20, 40, 40, 0, 255, 24'h0000FF);       // tiny window writes nothing
    run_random(10);
    drain();
    set_window(20, 20, 40, 40, 127, 200, 24'hFF0000);     // scale above full size
    run_random(20);
    drain();
    set_window(10, 10, 6, 12, 100, 255, 24'h808080);      // narrow window, no right corners
    run_random(20);
    drain();
    set_window(10, 10, 12, 10, 80, 255, 24'h123456);      // narrow after scaling
    run_random(20);
    drain();
  endtask

  // One block of random windows under the current idling profile.
  task automatic test_random_windows(int windows, int per_window);
    for (int k = 0; k < windows; k++) begin
      run_random_window(per_window);
      if (k == 1) begin
        // Hold the sender until the block has answered everything.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending_pixels.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk_i) begin
    pixel_result_t e;
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("result word with no prediction waiting: color %h write %b",
               pixel_color_o, write_pixel_o);
        err_count++;
      end else begin
        e = pending_pixels.pop_front();
        if (pixel_color_o !== e.color) begin
          $error("pixel_color expected %h actual %h", e.color, pixel_color_o);
          err_count++;
        end
        if (write_pixel_o !== e.write) begin
          $error("write_pixel expected %b actual %b", e.write, write_pixel_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 7;
    recv_idle_pct = 83;
    test_directed();
    test_extremes();
    test_random_windows(4, 35);
    send_idle_pct = 83;
    recv_idle_pct = 7;
    test_random_windows(4, 35);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_windows(4, 35);
    drain();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
